// File: rtl/matrix_orthonormalize_3x3_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the 3x3 orthonormalizer
// Concurrent checks clocked on clk_i; the module using them supplies clk_i
// and rst_ni.
// ----------------------------------------------------------------------------
`ifndef MATRIX_ORTHONORMALIZE_3X3_MACROS_SVH
`define MATRIX_ORTHONORMALIZE_3X3_MACROS_SVH

// Check that is ignored while reset is asserted
`define MO3_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Check that holds through reset as well
`define MO3_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error(msg);

`endif

// File: rtl/mo3_pkg.sv
// ----------------------------------------------------------------------------
// mo3_pkg
// Element format and beat payload types of the 3x3 orthonormalizer.
// ----------------------------------------------------------------------------
package mo3_pkg;

  localparam int unsigned ELEM_W = 32;
  localparam int unsigned FRAC_W = ELEM_W - 3;

  typedef logic signed [ELEM_W-1:0] elem_t;
  // index 0 is x, 1 is y, 2 is z
  typedef elem_t [2:0] vec_t;

  typedef struct packed {
    elem_t in_v0_x;
    elem_t in_v0_y;
    elem_t in_v0_z;
    elem_t in_v1_x;
    elem_t in_v1_y;
    elem_t in_v1_z;
    elem_t in_v2_x;
    elem_t in_v2_y;
    elem_t in_v2_z;
  } mo3_in_t;

  typedef struct packed {
    elem_t out_v0_x;
    elem_t out_v0_y;
    elem_t out_v0_z;
    elem_t out_v1_x;
    elem_t out_v1_y;
    elem_t out_v1_z;
    elem_t out_v2_x;
    elem_t out_v2_y;
    elem_t out_v2_z;
    logic  degenerate;
  } mo3_out_t;

endpackage

// File: rtl/mo3_norm.sv
// ----------------------------------------------------------------------------
// mo3_norm
// Pipelined normalization of one vector: squares, sum, one square root digit
// per stage, then one quotient bit per stage on all three elements.
// ----------------------------------------------------------------------------
module mo3_norm #(
  parameter int unsigned PASS_W = 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  mo3_pkg::vec_t      vec_i,
  input  logic [PASS_W-1:0]  pass_i,
  output logic               valid_o,
  output mo3_pkg::vec_t      unit_o,
  output logic               zero_o,
  output logic [PASS_W-1:0]  pass_o
);
  import mo3_pkg::*;

  localparam int unsigned W     = ELEM_W;
  localparam int unsigned DIV_N = FRAC_W + 1;

  // --------------------------------------------------------------------------
  // Squares
  logic [2*W-1:0]    sq_d [3];
  logic [2*W-1:0]    sq_q [3];
  vec_t              sq_vec_q;
  logic [PASS_W-1:0] sq_pass_q;
  logic              sq_val_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sq_d[i] = $unsigned((2*W)'(vec_i[i]) * (2*W)'(vec_i[i]));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_val_q <= 1'b0;
    end else if (en_i) begin
      sq_val_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) sq_q[i] <= sq_d[i];
      sq_vec_q  <= vec_i;
      sq_pass_q <= pass_i;
    end
  end

  // --------------------------------------------------------------------------
  // Sum of squares, then one root digit per stage
  logic [2*W-1:0]    rad_q   [W];
  logic [W+1:0]      rem_q   [W];
  logic [W-1:0]      root_q  [W+1];
  vec_t              svec_q  [W+1];
  logic [PASS_W-1:0] spass_q [W+1];
  logic              sval_q  [W+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sval_q[0] <= 1'b0;
    end else if (en_i) begin
      sval_q[0] <= sq_val_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rad_q[0]   <= sq_q[0] + sq_q[1] + sq_q[2];
      rem_q[0]   <= '0;
      root_q[0]  <= '0;
      svec_q[0]  <= sq_vec_q;
      spass_q[0] <= sq_pass_q;
    end
  end

  for (genvar k = 0; k < W; k++) begin : g_sqrt
    logic [W+1:0] rem_sh;
    logic [W+1:0] trial;
    logic [W+1:0] rem_n;
    logic         ge;

    // bring down two radicand bits and try the next root digit
    assign rem_sh = {rem_q[k][W-1:0], rad_q[k][2*W-1 -: 2]};
    assign trial  = {root_q[k], 2'b01};
    assign ge     = rem_sh >= trial;
    assign rem_n  = ge ? rem_sh - trial : rem_sh;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sval_q[k+1] <= 1'b0;
      end else if (en_i) begin
        sval_q[k+1] <= sval_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        root_q[k+1]  <= {root_q[k][W-2:0], ge};
        svec_q[k+1]  <= svec_q[k];
        spass_q[k+1] <= spass_q[k];
      end
    end

    if (k < W - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rad_q[k+1] <= rad_q[k] << 2;
          rem_q[k+1] <= rem_n;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Division setup: magnitudes and sign of each element
  logic [W-1:0]      r_q     [DIV_N][3];
  logic [W-1:0]      n_q     [DIV_N];
  logic [DIV_N-1:0]  q_q     [DIV_N+1][3];
  logic [2:0]        neg_q   [DIV_N+1];
  logic              dz_q    [DIV_N+1];
  logic [PASS_W-1:0] dpass_q [DIV_N+1];
  logic              dval_q  [DIV_N+1];
  logic [2:0]        lsb_q;
  logic [W-1:0]      mag     [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag[i] = svec_q[W][i][W-1] ? $unsigned(-svec_q[W][i]) : $unsigned(svec_q[W][i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dval_q[0] <= 1'b0;
    end else if (en_i) begin
      dval_q[0] <= sval_q[W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        r_q[0][i]   <= {1'b0, mag[i][W-1:1]};
        lsb_q[i]    <= mag[i][0];
        q_q[0][i]   <= '0;
        neg_q[0][i] <= svec_q[W][i][W-1];
      end
      n_q[0]     <= root_q[W];
      dz_q[0]    <= root_q[W] == '0;
      dpass_q[0] <= spass_q[W];
    end
  end

  // --------------------------------------------------------------------------
  // Restoring division, one quotient bit per stage
  for (genvar j = 0; j < DIV_N; j++) begin : g_div
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dval_q[j+1] <= 1'b0;
      end else if (en_i) begin
        dval_q[j+1] <= dval_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        neg_q[j+1]   <= neg_q[j];
        dz_q[j+1]    <= dz_q[j];
        dpass_q[j+1] <= dpass_q[j];
      end
    end

    if (j < DIV_N - 1) begin : g_den
      always_ff @(posedge clk_i) begin
        if (en_i) n_q[j+1] <= n_q[j];
      end
    end

    for (genvar i = 0; i < 3; i++) begin : g_lane
      logic       inb;
      logic [W:0] r2;
      logic [W:0] rn;
      logic       ge;

      // only the first step sees a nonzero dividend bit
      if (j == 0) begin : g_first
        assign inb = lsb_q[i];
      end else begin : g_rest
        assign inb = 1'b0;
      end

      assign r2 = {r_q[j][i], inb};
      assign ge = r2 >= {1'b0, n_q[j]};
      assign rn = ge ? r2 - {1'b0, n_q[j]} : r2;

      always_ff @(posedge clk_i) begin
        if (en_i) q_q[j+1][i] <= {q_q[j][i][DIV_N-2:0], ge};
      end

      if (j < DIV_N - 1) begin : g_rem
        always_ff @(posedge clk_i) begin
          if (en_i) r_q[j+1][i] <= rn[W-1:0];
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Apply signs, zero a vector of zero norm
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= dval_q[DIV_N];
    end
  end

  always_ff @(posedge clk_i) begin
    logic [W-1:0] qx;
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        qx = W'(q_q[DIV_N][i]);
        if (dz_q[DIV_N]) begin
          unit_o[i] <= '0;
        end else if (neg_q[DIV_N][i]) begin
          unit_o[i] <= $signed(-qx);
        end else begin
          unit_o[i] <= $signed(qx);
        end
      end
      zero_o <= dz_q[DIV_N];
      pass_o <= dpass_q[DIV_N];
    end
  end

endmodule

// File: rtl/mo3_proj.sv
// ----------------------------------------------------------------------------
// mo3_proj
// Four-stage removal of the projection of a vector on a unit vector, with
// saturation of each resulting element.
// ----------------------------------------------------------------------------
module mo3_proj #(
  parameter int unsigned PASS_W = 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  mo3_pkg::vec_t      unit_i,
  input  mo3_pkg::vec_t      vec_i,
  input  logic [PASS_W-1:0]  pass_i,
  output logic               valid_o,
  output mo3_pkg::vec_t      vec_o,
  output logic [PASS_W-1:0]  pass_o
);
  import mo3_pkg::*;

  localparam int unsigned W  = ELEM_W;
  localparam int unsigned SW = W + 3;
  localparam int unsigned MW = W + SW;
  localparam int unsigned PW = MW - FRAC_W;
  localparam int unsigned DW = PW + 1;

  logic signed [2*W-1:0] dp_q [3];
  logic signed [SW-1:0]  s_q;
  logic signed [MW-1:0]  m_q  [3];
  vec_t                  u0_q, u1_q;
  vec_t                  v0_q, v1_q, v2_q;
  logic [PASS_W-1:0]     pass0_q, pass1_q, pass2_q;
  logic                  val0_q, val1_q, val2_q;
  logic signed [2*W+1:0] dot;
  logic signed [DW-1:0]  diff [3];
  vec_t                  sat;

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val0_q  <= 1'b0;
      val1_q  <= 1'b0;
      val2_q  <= 1'b0;
      valid_o <= 1'b0;
    end else if (en_i) begin
      val0_q  <= valid_i;
      val1_q  <= val0_q;
      val2_q  <= val1_q;
      valid_o <= val2_q;
    end
  end

  // Dot product, floor shift, scaled unit vector, subtract
  always_comb begin
    dot = (2*W+2)'(dp_q[0]) + (2*W+2)'(dp_q[1]) + (2*W+2)'(dp_q[2]);
    for (int i = 0; i < 3; i++) begin
      // the shifted product is signed; keep its sign when widening
      diff[i] = DW'(v2_q[i]) - DW'($signed(m_q[i][MW-1:FRAC_W]));
      // saturate when the top bits disagree
      if (diff[i][DW-1:W-1] == '0 || diff[i][DW-1:W-1] == '1) begin
        sat[i] = diff[i][W-1:0];
      end else if (diff[i][DW-1]) begin
        sat[i] = {1'b1, {(W-1){1'b0}}};
      end else begin
        sat[i] = {1'b0, {(W-1){1'b1}}};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        dp_q[i] <= (2*W)'(unit_i[i]) * (2*W)'(vec_i[i]);
        m_q[i]  <= MW'(s_q) * MW'(u1_q[i]);
      end
      u0_q    <= unit_i;
      v0_q    <= vec_i;
      pass0_q <= pass_i;
      s_q     <= dot[FRAC_W+SW-1:FRAC_W];
      u1_q    <= u0_q;
      v1_q    <= v0_q;
      pass1_q <= pass0_q;
      v2_q    <= v1_q;
      pass2_q <= pass1_q;
      vec_o   <= sat;
      pass_o  <= pass2_q;
    end
  end

endmodule

// File: rtl/matrix_orthonormalize_3x3.sv
// ----------------------------------------------------------------------------
// matrix_orthonormalize_3x3: 3x3 Gram-Schmidt orthonormalizer
// Pipeline: three normalizations of 66 stages, two projections of 4.
// Throughput one matrix per cycle; a stalled output beat holds every stage.
// Reset clears the valid bit of each stage only; no clearing pass.
// ----------------------------------------------------------------------------
`include "matrix_orthonormalize_3x3_macros.svh"

module matrix_orthonormalize_3x3 (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  mo3_pkg::mo3_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output mo3_pkg::mo3_out_t out_data_o
);
  import mo3_pkg::*;

  localparam int unsigned VW = 3 * ELEM_W;
  localparam elem_t UNIT_POS = elem_t'(64'd1 << FRAC_W);
  localparam elem_t UNIT_NEG = -UNIT_POS;

  logic en;
  vec_t in_v0, in_v1, in_v2;

  // Advance the whole pipeline unless the output beat is held
  assign en         = !out_valid_o || !out_stall_i;
  assign in_stall_o = !en;

  assign in_v0 = {in_data_i.in_v0_z, in_data_i.in_v0_y, in_data_i.in_v0_x};
  assign in_v1 = {in_data_i.in_v1_z, in_data_i.in_v1_y, in_data_i.in_v1_x};
  assign in_v2 = {in_data_i.in_v2_z, in_data_i.in_v2_y, in_data_i.in_v2_x};

  // First vector
  logic            a_valid, a_zero;
  vec_t            a_u0, a_v1, a_v2;
  logic [2*VW-1:0] a_pass;

  mo3_norm #(.PASS_W(2*VW)) u_norm0 (
    .clk_i, .rst_ni, .en_i(en), .valid_i(in_valid_i), .vec_i(in_v0),
    .pass_i({in_v1, in_v2}), .valid_o(a_valid), .unit_o(a_u0),
    .zero_o(a_zero), .pass_o(a_pass)
  );
  assign {a_v1, a_v2} = a_pass;

  // Remove the first direction from the other two
  logic pa_valid, pb_valid, pb_deg;
  vec_t pa_vec, pb_vec, pa_u0;

  mo3_proj #(.PASS_W(VW)) u_proj10 (
    .clk_i, .rst_ni, .en_i(en), .valid_i(a_valid), .unit_i(a_u0),
    .vec_i(a_v1), .pass_i(a_u0), .valid_o(pa_valid), .vec_o(pa_vec),
    .pass_o(pa_u0)
  );

  mo3_proj #(.PASS_W(1)) u_proj20 (
    .clk_i, .rst_ni, .en_i(en), .valid_i(a_valid), .unit_i(a_u0),
    .vec_i(a_v2), .pass_i(a_zero), .valid_o(pb_valid), .vec_o(pb_vec),
    .pass_o(pb_deg)
  );

  // Second vector
  logic              c_valid, c_zero, c_deg;
  vec_t              c_u1, c_u0, c_v2;
  logic [2*VW:0]     c_pass;

  mo3_norm #(.PASS_W(2*VW+1)) u_norm1 (
    .clk_i, .rst_ni, .en_i(en), .valid_i(pa_valid && pb_valid), .vec_i(pa_vec),
    .pass_i({pa_u0, pb_vec, pb_deg}), .valid_o(c_valid), .unit_o(c_u1),
    .zero_o(c_zero), .pass_o(c_pass)
  );
  assign {c_u0, c_v2, c_deg} = c_pass;

  // Remove the second direction from the third vector
  logic          d_valid;
  vec_t          d_vec;
  logic [2*VW:0] d_pass;

  mo3_proj #(.PASS_W(2*VW+1)) u_proj21 (
    .clk_i, .rst_ni, .en_i(en), .valid_i(c_valid), .unit_i(c_u1),
    .vec_i(c_v2), .pass_i({c_u0, c_u1, c_deg || c_zero}), .valid_o(d_valid),
    .vec_o(d_vec), .pass_o(d_pass)
  );

  // Third vector; its last stage is the output register
  logic e_zero, e_deg;
  vec_t e_u0, e_u1, e_u2;

  mo3_norm #(.PASS_W(2*VW+1)) u_norm2 (
    .clk_i, .rst_ni, .en_i(en), .valid_i(d_valid), .vec_i(d_vec),
    .pass_i(d_pass), .valid_o(out_valid_o), .unit_o(e_u2),
    .zero_o(e_zero), .pass_o({e_u0, e_u1, e_deg})
  );

  assign out_data_o.out_v0_x   = e_u0[0];
  assign out_data_o.out_v0_y   = e_u0[1];
  assign out_data_o.out_v0_z   = e_u0[2];
  assign out_data_o.out_v1_x   = e_u1[0];
  assign out_data_o.out_v1_y   = e_u1[1];
  assign out_data_o.out_v1_z   = e_u1[2];
  assign out_data_o.out_v2_x   = e_u2[0];
  assign out_data_o.out_v2_y   = e_u2[1];
  assign out_data_o.out_v2_z   = e_u2[2];
  assign out_data_o.degenerate = e_deg || e_zero;

  // Checks
  `MO3_ASSERT_ALWAYS(a_stall_back, out_valid_o && out_stall_i |-> in_stall_o, "held output did not stall input")
  `MO3_ASSERT(a_deg_zero, out_valid_o && out_data_o.degenerate |-> (e_u0 == '0 || e_u1 == '0 || e_u2 == '0), "degenerate without a zero vector")
  `MO3_ASSERT(a_unit_range, out_valid_o |-> (e_u0[0] <= UNIT_POS && e_u0[0] >= UNIT_NEG && e_u2[2] <= UNIT_POS && e_u2[2] >= UNIT_NEG), "unit element beyond one")

endmodule
